/* sv/dvt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvt_pkg
// Shared types and constants for the distance-vector route table.
// ----------------------------------------------------------------------------
package dvt_pkg;

  localparam int DEFAULT_ROUTE_SLOTS = 16;
  localparam int MAX_RESULTS         = 16;
  localparam int RES_W               = $clog2(MAX_RESULTS + 1);
  localparam int LIST_W              = $clog2(MAX_RESULTS);

  localparam logic [15:0] DIST_MAX = 16'hFFFF;

  localparam logic [1:0] OP_ENTRY = 2'd0;
  localparam logic [1:0] OP_EMIT  = 2'd1;
  localparam logic [1:0] OP_SENT  = 2'd2;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] neighbor;
    logic [15:0] metric;
  } slot_t;

endpackage

/* sv/dvt_slot_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvt_slot_ram
// Route slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dvt_slot_ram #(
  parameter int DEPTH = dvt_pkg::DEFAULT_ROUTE_SLOTS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  dvt_pkg::slot_t wdata,
  input  logic [AW-1:0]  raddr,
  output dvt_pkg::slot_t rdata
);

  dvt_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/distance_vector_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_table_unit
// Route table kept in a slot RAM; entries update by read-scan-write, emit
// walks the slots newest first and scans the table per distinct destination.
// ----------------------------------------------------------------------------
// Entry: one RAM read per slot. Emit: per slot a read and a check; per
// distinct destination a further scan of the table and one hand-off, and
// output stalls can hold it; one item at a time.
// Reset (rst, synchronous): table empty, pending flag clear, no output held.
// No clearing pass: slots above the fill count are never read.
module distance_vector_table_unit #(
  parameter int ROUTE_SLOTS = dvt_pkg::DEFAULT_ROUTE_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // neighbor_addr[31:0], dest_addr[63:32], neighbor_dist[79:64]
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // route_dest, best_dist, route_valid, changed,
                                 // table_full, update_pending, zero pad
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // last
);

  localparam int AW = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam int CW = $clog2(ROUTE_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ESCAN = 3'd1;
  localparam logic [2:0] S_EFIN  = 3'd2;
  localparam logic [2:0] S_CRD   = 3'd3;
  localparam logic [2:0] S_CCHK  = 3'd4;
  localparam logic [2:0] S_MSCAN = 3'd5;
  localparam logic [2:0] S_MNEXT = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic          pending;
  logic [1:0]    op;
  logic [31:0]   nb;
  logic [31:0]   dst;
  logic [15:0]   nv;
  logic          chg;
  logic          full;
  logic [CW-1:0] idx;
  logic [AW-1:0] ridx;
  logic          rv;
  logic [AW-1:0] cand;
  logic [dvt_pkg::RES_W-1:0] n;
  logic [31:0]   list [dvt_pkg::MAX_RESULTS];
  logic [31:0]   cur;
  logic [15:0]   best;
  logic          h_v;
  logic [31:0]   h_dest;
  logic [15:0]   h_dist;

  // output register
  logic          o_valid;
  logic [1:0]    o_kind;
  logic [31:0]   o_dest;
  logic [15:0]   o_dist;
  logic          o_rv;
  logic          o_last;
  logic          o_chg;
  logic          o_full;
  logic          o_pend;

  logic           we;
  logic [AW-1:0]  waddr;
  dvt_pkg::slot_t wdata;
  logic [AW-1:0]  raddr;
  dvt_pkg::slot_t rdata;

  logic          issue;
  logic          seen;
  logic [CW-1:0] cnt_m1;
  logic [15:0]   in_nv;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = o_valid;
  assign m_tuser  = o_kind;
  assign m_tlast  = o_last;
  assign m_tdata  = {4'd0, o_pend, o_full, o_chg, o_rv, o_dist, o_dest};

  assign issue  = (idx < cnt);
  assign cnt_m1 = cnt - CW'(1);
  assign in_nv  = (s_tdata[79:64] == dvt_pkg::DIST_MAX) ? dvt_pkg::DIST_MAX
                                                        : s_tdata[79:64] + 16'd1;
  assign raddr  = (state == S_CRD) ? cand : idx[AW-1:0];

  always_comb begin
    seen = 1'b0;
    for (int k = 0; k < dvt_pkg::MAX_RESULTS; k++) begin
      if ((dvt_pkg::RES_W'(k) < n) && (list[k] == rdata.dest)) begin
        seen = 1'b1;
      end
    end
  end

  // RAM write: match update or new slot, at the end of an entry scan
  always_comb begin
    we    = 1'b0;
    waddr = cnt[AW-1:0];
    wdata = '{dest: dst, neighbor: nb, metric: nv};
    if (state == S_ESCAN) begin
      if (rv && rdata.dest == dst && rdata.neighbor == nb) begin
        we    = (rdata.metric != nv);
        waddr = ridx;
      end else if (!rv && !issue) begin
        we    = (cnt < CW'(ROUTE_SLOTS));
      end
    end
  end

  dvt_slot_ram #(
    .DEPTH (ROUTE_SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      pending <= 1'b0;
      o_valid <= 1'b0;
      rv      <= 1'b0;
      h_v     <= 1'b0;
      n       <= '0;
    end else begin
      if (o_valid && m_tready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op   <= s_tuser;
            nb   <= s_tdata[31:0];
            dst  <= s_tdata[63:32];
            nv   <= in_nv;
            chg  <= 1'b0;
            full <= 1'b0;
            idx  <= '0;
            rv   <= 1'b0;
            n    <= '0;
            h_v  <= 1'b0;
            case (s_tuser)
              dvt_pkg::OP_ENTRY: state <= S_ESCAN;
              dvt_pkg::OP_EMIT: begin
                cand  <= cnt_m1[AW-1:0];
                state <= (cnt == '0) ? S_FIN : S_CRD;
              end
              dvt_pkg::OP_SENT: begin
                pending <= 1'b0;
                state   <= S_EFIN;
              end
              default: state <= S_EFIN;
            endcase
          end
        end
        S_ESCAN: begin
          if (issue) begin
            idx <= idx + CW'(1);
          end
          rv   <= issue;
          ridx <= idx[AW-1:0];
          if (rv && rdata.dest == dst && rdata.neighbor == nb) begin
            if (rdata.metric != nv) begin
              chg     <= 1'b1;
              pending <= 1'b1;
            end
            state <= S_EFIN;
          end else if (!rv && !issue) begin
            if (cnt < CW'(ROUTE_SLOTS)) begin
              cnt     <= cnt + CW'(1);
              chg     <= 1'b1;
              pending <= 1'b1;
            end else begin
              full <= 1'b1;
            end
            state <= S_EFIN;
          end
        end
        S_EFIN: begin
          if (!o_valid) begin
            o_valid <= 1'b1;
            o_kind  <= op;
            o_dest  <= '0;
            o_dist  <= '0;
            o_rv    <= 1'b0;
            o_last  <= 1'b1;
            o_chg   <= chg;
            o_full  <= full;
            o_pend  <= pending;
            state   <= S_IDLE;
          end
        end
        S_CRD: begin
          state <= S_CCHK;
        end
        S_CCHK: begin
          if (seen) begin
            if (cand == '0) begin
              state <= S_FIN;
            end else begin
              cand  <= cand - AW'(1);
              state <= S_CRD;
            end
          end else begin
            cur   <= rdata.dest;
            best  <= dvt_pkg::DIST_MAX;
            idx   <= '0;
            rv    <= 1'b0;
            state <= S_MSCAN;
          end
        end
        S_MSCAN: begin
          if (issue) begin
            idx <= idx + CW'(1);
          end
          rv <= issue;
          if (rv && rdata.dest == cur && rdata.metric < best) begin
            best <= rdata.metric;
          end
          if (!rv && !issue) begin
            state <= S_MNEXT;
          end
        end
        S_MNEXT: begin
          // previous element goes out once another one is known to follow
          if (!h_v || !o_valid) begin
            if (h_v) begin
              o_valid <= 1'b1;
              o_kind  <= dvt_pkg::OP_EMIT;
              o_dest  <= h_dest;
              o_dist  <= h_dist;
              o_rv    <= 1'b1;
              o_last  <= 1'b0;
              o_chg   <= 1'b0;
              o_full  <= 1'b0;
              o_pend  <= pending;
            end
            h_v     <= 1'b1;
            h_dest  <= cur;
            h_dist  <= best;
            list[n[dvt_pkg::LIST_W-1:0]] <= cur;
            n       <= n + dvt_pkg::RES_W'(1);
            if (n == dvt_pkg::RES_W'(dvt_pkg::MAX_RESULTS - 1) || cand == '0) begin
              state <= S_FIN;
            end else begin
              cand  <= cand - AW'(1);
              state <= S_CRD;
            end
          end
        end
        S_FIN: begin
          if (!o_valid) begin
            o_valid <= 1'b1;
            o_kind  <= dvt_pkg::OP_EMIT;
            o_dest  <= h_v ? h_dest : 32'd0;
            o_dist  <= h_v ? h_dist : 16'd0;
            o_rv    <= h_v;
            o_last  <= 1'b1;
            o_chg   <= 1'b0;
            o_full  <= 1'b0;
            o_pend  <= pending;
            h_v     <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* bench/distance_vector_table_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_table_unit_test
// Self-checking bench for the route table: a behavioural table model predicts
// every result transaction, which is compared with all fields at once on the output.
// ----------------------------------------------------------------------------
module distance_vector_table_unit_test;

  localparam int SLOTS     = dvt_pkg::DEFAULT_ROUTE_SLOTS;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] OP_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] dest;
    logic [15:0] metric;
    logic        valid;
    logic        last;
    logic        chg;
    logic        full;
    logic        pend;
  } route_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  distance_vector_table_unit dut (.*);

  always #5 clk = ~clk;

  // table model
  logic [31:0] tbl_dest [SLOTS];
  logic [31:0] tbl_nb   [SLOTS];
  logic [15:0] tbl_dist [SLOTS];
  int          tbl_count;
  logic        tbl_pend;

  route_res_t  expected_routes[$];
  int          send_idle_pct, stall_pct;
  int          errors;
  int          idle_cycles;

  function automatic route_res_t mk(logic [1:0] k, logic [31:0] d, logic [15:0] ds,
                                    logic v, logic l, logic c, logic f);
    route_res_t r;
    r.kind = k; r.dest = d; r.metric = ds; r.valid = v; r.last = l;
    r.chg = c; r.full = f; r.pend = tbl_pend;
    return r;
  endfunction

  task automatic predict_routes(logic [1:0] op, logic [31:0] nb, logic [31:0] dst,
                                logic [15:0] nd);
    logic [15:0] nv, best;
    logic chg, full, found, seen;
    int n;
    chg = 0; full = 0; found = 0; n = 0;
    case (op)
      dvt_pkg::OP_ENTRY: begin
        nv = (nd == dvt_pkg::DIST_MAX) ? dvt_pkg::DIST_MAX : nd + 16'd1;
        for (int i = 0; i < tbl_count; i++) begin
          if (!found && tbl_dest[i] == dst && tbl_nb[i] == nb) begin
            found = 1;
            if (tbl_dist[i] != nv) begin
              tbl_dist[i] = nv;
              chg = 1;
            end
          end
        end
        if (!found) begin
          if (tbl_count < SLOTS) begin
            tbl_dest[tbl_count] = dst; tbl_nb[tbl_count] = nb;
            tbl_dist[tbl_count] = nv; tbl_count++;
            chg = 1;
          end else full = 1;
        end
        if (chg) tbl_pend = 1;
        expected_routes.push_back(mk(dvt_pkg::OP_ENTRY, 0, 0, 0, 1, chg, full));
      end
      dvt_pkg::OP_EMIT: begin
        for (int s = tbl_count - 1; s >= 0 && n < dvt_pkg::MAX_RESULTS; s--) begin
          seen = 0;
          for (int j = s + 1; j < tbl_count; j++)
            if (tbl_dest[j] == tbl_dest[s]) seen = 1;
          if (!seen) begin
            best = dvt_pkg::DIST_MAX;
            for (int j = 0; j < tbl_count; j++)
              if (tbl_dest[j] == tbl_dest[s] && tbl_dist[j] < best) best = tbl_dist[j];
            expected_routes.push_back(mk(dvt_pkg::OP_EMIT, tbl_dest[s], best, 1, 0, 0, 0));
            n++;
          end
        end
        if (n == 0) expected_routes.push_back(mk(dvt_pkg::OP_EMIT, 0, 0, 0, 1, 0, 0));
        else expected_routes[$].last = 1'b1;
      end
      dvt_pkg::OP_SENT: begin
        tbl_pend = 0;
        expected_routes.push_back(mk(dvt_pkg::OP_SENT, 0, 0, 0, 1, 0, 0));
      end
      default: expected_routes.push_back(mk(OP_BAD, 0, 0, 0, 1, 0, 0));
    endcase
  endtask

  // driven with blocking writes at the falling edge, so back-to-back items
  // can drop and raise tvalid in the same step
  task automatic send_item(logic [1:0] op, logic [31:0] nb, logic [31:0] dst,
                           logic [15:0] nd);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {nd, dst, nb};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_routes(op, nb, dst, nd);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic drain;
    while (expected_routes.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // receiver stall pattern
  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  // result checker
  always @(posedge clk) begin
    route_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[31:0], m_tdata[47:32], m_tdata[48], m_tlast,
             m_tdata[49], m_tdata[50], m_tdata[51]};
      if (expected_routes.size() == 0) begin
        $display("%0t: unexpected result exp none act %h", $time, got);
        errors++;
      end else begin
        want = expected_routes.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch exp %h act %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("distance_vector_table_unit test failed");
      $finish;
    end
  end

  task automatic set_idling(int snd, int rcv);
    send_idle_pct = snd;
    stall_pct = rcv;
  endtask

  task automatic test_directed;
    send_item(dvt_pkg::OP_EMIT, 0, 0, 0);                      // empty table
    send_item(dvt_pkg::OP_SENT, 0, 0, 0);
    send_item(OP_BAD, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    send_item(dvt_pkg::OP_ENTRY, 32'h0, 32'h0, 16'h0);
    send_item(dvt_pkg::OP_ENTRY, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF); // saturates
    send_item(dvt_pkg::OP_ENTRY, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFE); // same value
    send_item(dvt_pkg::OP_ENTRY, 32'h1, 32'h0, 16'h5);
    send_item(dvt_pkg::OP_ENTRY, 32'h0, 32'h0, 16'h7);         // update, larger
    send_item(dvt_pkg::OP_EMIT, 0, 0, 0);
    send_item(dvt_pkg::OP_SENT, 0, 0, 0);
    send_item(dvt_pkg::OP_ENTRY, 32'h1, 32'h0, 16'h5);         // unchanged, pend stays low
    send_item(OP_BAD, 0, 0, 0);
    for (int i = 0; i < 14; i++)
      send_item(dvt_pkg::OP_ENTRY, 32'hA0 + i, 32'h100 + i, 16'(i));
    send_item(dvt_pkg::OP_ENTRY, 32'h55, 32'h55, 16'h1);       // table full
    send_item(dvt_pkg::OP_EMIT, 0, 0, 0);
    drain();
  endtask

  task automatic test_random(int count);
    logic [1:0] op;
    logic [31:0] nb, dst;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      op = (r < 60) ? dvt_pkg::OP_ENTRY : (r < 80) ? dvt_pkg::OP_EMIT :
           (r < 95) ? dvt_pkg::OP_SENT : OP_BAD;
      // mostly small address pools so matches happen; sometimes full range
      nb  = $urandom_range(3) == 0 ? $urandom : $urandom_range(3);
      dst = $urandom_range(3) == 0 ? $urandom : $urandom_range(5);
      send_item(op, nb, dst, $urandom_range(7) == 0 ? 16'hFFFF : 16'($urandom));
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    tbl_count = 0;
    tbl_pend = 0;
    set_idling(0, 0);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    // the table stays full from here; reset is not repeated, so random
    // items still hit updates of the stored pairs and full drops
    set_idling(0, 0);   test_random(50);
    set_idling(73, 0);  test_random(50);
    drain();            // sender holds off until all results are in
    set_idling(0, 73);  test_random(50);
    set_idling(13, 13); test_random(50);
    drain();
    if (errors == 0) begin
      $display("distance_vector_table_unit test passed");
    end else begin
      $display("distance_vector_table_unit test failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/dvt_pkg.sv
sv/dvt_slot_ram.sv
sv/distance_vector_table_unit.sv
bench/distance_vector_table_unit_test.sv
